// ===== rtl/ramped_setpoint_p_steering_assert.svh =====
// ----------------------------------------------------------------------------
// ramped_setpoint_p_steering_assert.svh
// Assertion macros shared by the top-level and core steering controller modules
// ----------------------------------------------------------------------------
`ifndef RAMPED_SETPOINT_P_STEERING_ASSERT_SVH
`define RAMPED_SETPOINT_P_STEERING_ASSERT_SVH

// plain property, checked outside reset
`define RSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication, checked outside reset
`define RSPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RSPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rsps_pkg.sv =====
// ----------------------------------------------------------------------------
// rsps_pkg
// Types and constants of the ramped-setpoint steering controller
// ----------------------------------------------------------------------------
package rsps_pkg;

  localparam int unsigned RangeW = 10;
  localparam int unsigned AngleW = 8;
  localparam int unsigned GainW  = 8;
  localparam int unsigned StepW  = 8;
  localparam int unsigned SelW   = 2;
  localparam int unsigned ProbeW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [AngleW-1:0] CenterAngle = 8'd90;
  localparam logic [RangeW-1:0] StartGap    = 10'd10;
  localparam logic [ProbeW-1:0] ProbeLimit  = 3'd4;
  localparam logic signed [AngleW-1:0] CorrHi = 8'sd60;
  localparam logic signed [AngleW-1:0] CorrLo = -8'sd50;

  localparam logic [GainW-1:0]  GainRst   = 8'd1;
  localparam logic [RangeW-1:0] TargetRst = 10'd50;
  localparam logic [StepW-1:0]  StepRst   = 8'd1;
  localparam logic [RangeW-1:0] SetpRst   = 10'd50;

  typedef enum logic [CfgIdxW-1:0] {
    RegGain   = 3'd0,
    RegTarget = 3'd1,
    RegStep   = 3'd2,
    RegSelect = 3'd3,
    RegEdge   = 3'd4
  } cfg_idx_e;

  typedef enum logic [SelW-1:0] {
    SelIdle  = 2'd0,
    SelLeft  = 2'd1,
    SelRight = 2'd2,
    SelNone  = 2'd3
  } sel_e;

  typedef enum logic {
    KindStart = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [RangeW-1:0] target_distance;
    logic [StepW-1:0]  ramp_step;
    sel_e              sensor_select;
    logic [RangeW-1:0] edge_distance;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [RangeW-1:0] range_one;
    logic [RangeW-1:0] range_two;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_angle;
    logic              servo_update;
    logic              corner_found;
    logic              corner_new;
    logic              turn_way;
    logic [RangeW-1:0] held_setpoint;
  } result_t;

endpackage

// ===== rtl/rsps_in_if.sv =====
// ----------------------------------------------------------------------------
// rsps_in_if
// Input channel: start events and control ticks with two range readings
// ----------------------------------------------------------------------------
interface rsps_in_if import rsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [RangeW-1:0] range_one;
  logic [RangeW-1:0] range_two;

  modport source (output valid, output kind, output range_one, output range_two,
                  input ready);
  modport sink (input valid, input kind, input range_one, input range_two,
                output ready);
endinterface

// ===== rtl/rsps_out_if.sv =====
// ----------------------------------------------------------------------------
// rsps_out_if
// Result channel: servo command, corner status and held setpoint
// ----------------------------------------------------------------------------
interface rsps_out_if import rsps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AngleW-1:0] servo_angle;
  logic              servo_update;
  logic              corner_found;
  logic              corner_new;
  logic              turn_way;
  logic [RangeW-1:0] held_setpoint;

  modport source (output valid, output servo_angle, output servo_update,
                  output corner_found, output corner_new, output turn_way,
                  output held_setpoint, input ready);
  modport sink (input valid, input servo_angle, input servo_update,
                input corner_found, input corner_new, input turn_way,
                input held_setpoint, output ready);
endinterface

// ===== rtl/ramped_setpoint_p_steering.sv =====
// ----------------------------------------------------------------------------
// ramped_setpoint_p_steering
// Wall-distance steering controller with ramped setpoint (top level)
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    kind, range_one, range_two
//  result_o  out  valid/ready    servo_angle, servo_update, corner_found,
//                                corner_new, turn_way, held_setpoint
//  cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// one beat per cycle sustained while result_o.ready is high; a beat passes
// the input register, then core logic into the result register
// the multiply-and-clamp between input and result register sets the cycle time
// async active-low reset puts setpoint to 50, flags and probe count to zero
// input register takes a new beat while the result waits, so one stalled
// result plus one held input beat are buffered before ready drops
// ----------------------------------------------------------------------------
module ramped_setpoint_p_steering import rsps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  rsps_in_if.sink             item_i,
  rsps_out_if.source          result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   in_q;
  result_t res_d, res_q;
  logic    in_vld_q, out_vld_q;
  logic    adv, accept;

  rsps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // beat moves into the result register when that register is free or drained
  assign adv          = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready = !in_vld_q || adv;
  assign accept       = item_i.valid && item_i.ready;

  rsps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.kind      <= kind_e'(item_i.kind);
      in_q.range_one <= item_i.range_one;
      in_q.range_two <= item_i.range_two;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.servo_angle   = res_q.servo_angle;
  assign result_o.servo_update  = res_q.servo_update;
  assign result_o.corner_found  = res_q.corner_found;
  assign result_o.corner_new    = res_q.corner_new;
  assign result_o.turn_way      = res_q.turn_way;
  assign result_o.held_setpoint = res_q.held_setpoint;

`include "ramped_setpoint_p_steering_assert.svh"

  `RSPS_ASSERT_IMP(a_idle_center, out_vld_q && !res_q.servo_update, res_q.servo_angle == CenterAngle, "servo angle off center without update")
  `RSPS_ASSERT_IMP(a_new_found, out_vld_q && res_q.corner_new, res_q.corner_found, "new corner reported without corner flag")
  `RSPS_ASSERT_NXT(a_hold_input, in_vld_q && !adv, in_vld_q, "held input beat dropped while stalled")

endmodule

// ===== rtl/rsps_cfg.sv =====
// ----------------------------------------------------------------------------
// rsps_cfg
// Configuration register bank, written by index
// ----------------------------------------------------------------------------
module rsps_cfg import rsps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegGain:   cfg_d.gain            = cfg_wdata_i[GainW-1:0];
        RegTarget: cfg_d.target_distance = cfg_wdata_i[RangeW-1:0];
        RegStep:   cfg_d.ramp_step       = cfg_wdata_i[StepW-1:0];
        RegSelect: cfg_d.sensor_select   = sel_e'(cfg_wdata_i[SelW-1:0]);
        RegEdge:   cfg_d.edge_distance   = cfg_wdata_i[RangeW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain            <= GainRst;
      cfg_q.target_distance <= TargetRst;
      cfg_q.ramp_step       <= StepRst;
      cfg_q.sensor_select   <= SelIdle;
      cfg_q.edge_distance   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rsps_core.sv =====
// ----------------------------------------------------------------------------
// rsps_core
// Setpoint ramp, proportional servo angle and corner detection for one beat
// ----------------------------------------------------------------------------
module rsps_core import rsps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [RangeW-1:0] sp_q, sp_d;
  logic              flag_q, flag_d;
  logic              way_q, way_d;
  logic [ProbeW-1:0] probe_q, probe_d;

  logic [RangeW-1:0]          sp_ramp;
  logic [RangeW:0]            hi_lhs, hi_rhs, lo_lhs, lo_rhs;
  logic                       left;
  logic                       active;
  logic [RangeW-1:0]          reading;
  logic signed [RangeW+1:0]   err;
  logic signed [RangeW+GainW+2:0] prod;
  logic signed [AngleW-1:0]   corr;
  logic [RangeW-1:0]          gap;
  logic                       update, fresh;

  // ramp toward the target, snapping once within one step; hold while the target is zero
  assign hi_lhs = {1'b0, sp_q} + 11'd1;
  assign hi_rhs = {1'b0, cfg_i.target_distance} + {3'b000, cfg_i.ramp_step};
  assign lo_lhs = {1'b0, sp_q} + {3'b000, cfg_i.ramp_step};
  assign lo_rhs = {1'b0, cfg_i.target_distance} + 11'd1;

  always_comb begin
    if (cfg_i.target_distance == '0) begin
      sp_ramp = sp_q;
    end else if (hi_lhs > hi_rhs) begin
      sp_ramp = sp_q - {2'b00, cfg_i.ramp_step};
    end else if (lo_lhs < lo_rhs) begin
      sp_ramp = lo_lhs[RangeW-1:0];
    end else begin
      sp_ramp = cfg_i.target_distance;
    end
  end

  assign left    = (cfg_i.sensor_select == SelLeft);
  assign active  = cfg_i.sensor_select inside {SelLeft, SelRight};
  assign reading = left ? item_i.range_one : item_i.range_two;

  // both sides reduce to 90 + clamp(err * gain, -50, 60)
  assign err  = $signed({2'b00, sp_ramp}) - $signed({2'b00, reading});
  assign prod = err * $signed({1'b0, cfg_i.gain});

  always_comb begin
    if (prod > (RangeW+GainW+3)'(CorrHi)) begin
      corr = CorrHi;
    end else if (prod < (RangeW+GainW+3)'(CorrLo)) begin
      corr = CorrLo;
    end else begin
      corr = prod[AngleW-1:0];
    end
  end

  assign gap = (item_i.range_one > item_i.range_two) ?
               (item_i.range_one - item_i.range_two) :
               (item_i.range_two - item_i.range_one);

  always_comb begin
    sp_d    = sp_q;
    flag_d  = flag_q;
    way_d   = way_q;
    probe_d = probe_q;
    update  = 1'b0;
    fresh   = 1'b0;
    if (item_i.kind == KindStart) begin
      update = 1'b1;
      flag_d = 1'b0;
      if (item_i.range_one != '0 && item_i.range_two != '0 && gap > StartGap) begin
        flag_d = 1'b1;
        fresh  = 1'b1;
        way_d  = !(item_i.range_one < item_i.range_two);
      end
    end else if (active) begin
      sp_d = sp_ramp;
      if (reading != '0) begin
        update = 1'b1;
        if (!flag_q && cfg_i.edge_distance != '0) begin
          if (reading > cfg_i.edge_distance) begin
            flag_d = 1'b1;
            fresh  = 1'b1;
            way_d  = !left;
          end
          // probe of the left reading wins the direction in right mode
          if (probe_q == ProbeLimit) begin
            if (!left && item_i.range_one > cfg_i.edge_distance) begin
              flag_d = 1'b1;
              fresh  = 1'b1;
              way_d  = 1'b0;
            end
          end else begin
            probe_d = probe_q + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.servo_angle   = CenterAngle;
    if (update && item_i.kind == KindTick) begin
      res_o.servo_angle = CenterAngle + corr;
    end
    res_o.servo_update  = update;
    res_o.corner_found  = flag_d;
    res_o.corner_new    = fresh;
    res_o.turn_way      = way_d;
    res_o.held_setpoint = sp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q    <= SetpRst;
      flag_q  <= 1'b0;
      way_q   <= 1'b0;
      probe_q <= '0;
    end else if (adv_i) begin
      sp_q    <= sp_d;
      flag_q  <= flag_d;
      way_q   <= way_d;
      probe_q <= probe_d;
    end
  end

`include "ramped_setpoint_p_steering_assert.svh"

  `RSPS_ASSERT(a_probe_step, $stable(probe_q) || (probe_q == $past(probe_q) + 3'd1 && probe_q <= ProbeLimit), "probe counter moved other than by one up to its limit")

endmodule
